@@ hdl/zbpa_pkg.sv @@
// Shared types and constants for the zoned bitmap page allocator.
package zbpa_pkg;

	localparam int CFG_W  = 12;
	localparam int ADDR_W = 32;
	localparam int SIZE_W = 32;

	// Configuration register indexes
	localparam logic [1:0] REG_DMA_FIRST    = 2'd0;
	localparam logic [1:0] REG_DMA_LAST     = 2'd1;
	localparam logic [1:0] REG_NORMAL_FIRST = 2'd2;
	localparam logic [1:0] REG_NORMAL_LAST  = 2'd3;

	typedef enum logic [1:0] {
		OP_INIT  = 2'd0,
		OP_FREE  = 2'd1,
		OP_USED  = 2'd2,
		OP_ALLOC = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_READY = 2'd1,
		ST_REJECT    = 2'd2,
		ST_NO_RUN    = 2'd3
	} st_t;

	typedef enum logic [1:0] {
		BASE_ZERO  = 2'd0,
		BASE_FIRST = 2'd1,
		BASE_START = 2'd2
	} base_t;

	typedef struct packed {
		logic  load;
		logic  div_start;
		logic  div_size;
		logic  save_first;
		logic  save_count;
		logic  init_commit;
		logic  fill_start;
		base_t fill_base;
		logic  fill_all;
		logic  fill_val;
		logic  fill_step;
		logic  scan_start;
		logic  scan_step;
		logic  mul_step;
		logic  res_load;
		st_t   res_status;
		logic  res_addr;
	} zbpa_cmd_t;

	typedef struct packed {
		op_t  op;
		logic ready;
		logic div_done;
		logic init_ok;
		logic mark_ok;
		logic alloc_reject;
		logic alloc_too_big;
		logic fill_empty;
		logic scan_found;
		logic scan_end;
		logic out_free;
	} zbpa_sts_t;

endpackage

@@ hdl/zbpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module zbpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/zbpa_div.sv @@
// Division by a fixed divisor through reciprocal multiplication, with a saturating quotient.
module zbpa_div #(
	parameter int DIVISOR = 4096,
	parameter int NUM_W   = 33,
	parameter int QUOT_W  = 14
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [NUM_W-1:0]  numer,
	output logic [QUOT_W-1:0] quot,
	output logic              done
);

	// quotients of QUOT_MAX and above all read as QUOT_MAX
	localparam longint unsigned QUOT_MAX = 64'd1 << (QUOT_W - 1);
	localparam longint unsigned NUM_LIM  = QUOT_MAX * 64'(DIVISOR);
	localparam int              N_W      = $clog2(NUM_LIM);
	localparam int              SHIFT    = N_W + $clog2(DIVISOR);
	localparam int              M_W      = N_W + 2;
	localparam longint unsigned RECIP    =
		((64'd1 << SHIFT) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam int              PROD_W   = N_W + M_W;

	logic [N_W-1:0]    num_q;
	logic              sat_q;
	logic              busy_q;
	logic              done_q;
	logic [QUOT_W-1:0] quot_q;
	logic [PROD_W-1:0] prod;

	// exact below NUM_LIM: the reciprocal is rounded up with enough fraction bits
	assign prod = PROD_W'(num_q) * PROD_W'(RECIP);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			busy_q <= start;
			done_q <= busy_q;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= N_W'(numer);
			sat_q <= 64'(numer) >= NUM_LIM;
		end
		if (busy_q) begin
			quot_q <= sat_q ? QUOT_W'(QUOT_MAX) : QUOT_W'(prod >> SHIFT);
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

@@ hdl/zbpa_dp.sv @@
// Datapath: registers, page bitmap, divider, scan and fill counters, result register.
module zbpa_dp import zbpa_pkg::*; #(
	parameter int PAGES      = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic              zone_select,
	input  logic              out_stall,
	output logic              out_valid,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] alloc_address,
	input  zbpa_cmd_t         cmd,
	output zbpa_sts_t         sts
);

	localparam int PG_W   = $clog2(PAGES);
	localparam int CNT_W  = $clog2(PAGES + 1);
	localparam int PB_W   = $clog2(PAGE_BYTES + 1);
	localparam int PROD_W = PG_W + PB_W;
	localparam int Q_W    = SIZE_W + 1;
	// page quotients saturate above any bound, which keeps every check intact
	localparam int DQ_W   = CFG_W + 2;
	localparam int WIDE_W = DQ_W + 1;

	// configuration and latched bounds
	logic [CFG_W-1:0] c_dmin_q, c_dmax_q, c_nmin_q, c_nmax_q;
	logic [CFG_W-1:0] l_dmin_q, l_dmax_q, l_nmin_q, l_nmax_q;
	logic             ready_q;

	// item registers
	op_t               op_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;
	logic              zone_q;

	logic [Q_W-1:0]  div_numer;
	logic [DQ_W-1:0] div_quot;
	logic            div_done;
	logic [DQ_W-1:0] first_q, count_q;

	// scan
	logic [CNT_W-1:0] rd_p_q, eval_p_q, run_q;
	logic             pipe_v_q;
	logic [PG_W-1:0]  start_q;
	logic             rd_data;

	// fill
	logic [PG_W-1:0]  fill_ptr_q;
	logic [CNT_W-1:0] fill_left_q;
	logic             fill_val_q;
	logic [PG_W-1:0]  fill_base;

	logic [PROD_W-1:0] prod_q;

	logic              out_valid_q;
	st_t               status_q;
	logic [ADDR_W-1:0] addr_out_q;

	logic [CFG_W-1:0]  top, lo, hi;
	logic [WIDE_W-1:0] mark_last, span;
	logic              init_bad;
	logic              issue_v;
	logic [CNT_W-1:0]  need;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_dmin_q <= '0;
			c_dmax_q <= '0;
			c_nmin_q <= '0;
			c_nmax_q <= '0;
			l_dmin_q <= '0;
			l_dmax_q <= '0;
			l_nmin_q <= '0;
			l_nmax_q <= '0;
			ready_q  <= 1'b0;
		end else begin
			if (cfg_write_en) begin
				unique case (cfg_index)
					REG_DMA_FIRST:    c_dmin_q <= cfg_data;
					REG_DMA_LAST:     c_dmax_q <= cfg_data;
					REG_NORMAL_FIRST: c_nmin_q <= cfg_data;
					REG_NORMAL_LAST:  c_nmax_q <= cfg_data;
					default:          c_dmin_q <= c_dmin_q;
				endcase
			end
			if (cmd.init_commit) begin
				l_dmin_q <= c_dmin_q;
				l_dmax_q <= c_dmax_q;
				l_nmin_q <= c_nmin_q;
				l_nmax_q <= c_nmax_q;
				ready_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q   <= op_t'(opcode);
			addr_q <= byte_address;
			size_q <= size_bytes;
			zone_q <= zone_select;
		end
		if (cmd.save_first) begin
			first_q <= div_quot;
		end
		if (cmd.save_count) begin
			count_q <= div_quot;
		end
	end

	// size is rounded up to whole pages by biasing the numerator
	assign div_numer = cmd.div_size ? Q_W'(size_q) + Q_W'(PAGE_BYTES - 1) : Q_W'(addr_q);

	zbpa_div #(
		.DIVISOR (PAGE_BYTES),
		.NUM_W   (Q_W),
		.QUOT_W  (DQ_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.numer  (div_numer),
		.quot   (div_quot),
		.done   (div_done)
	);

	// checks
	assign init_bad = (c_dmin_q == '0)
		|| (32'(c_dmax_q) >= 32'(PAGES)) || (32'(c_nmax_q) >= 32'(PAGES))
		|| (c_dmin_q > c_dmax_q)
		|| ((c_nmin_q != '0) && ((c_dmax_q >= c_nmin_q) || (c_nmin_q > c_nmax_q)));

	assign top       = (l_nmin_q != '0) ? l_nmax_q : l_dmax_q;
	assign mark_last = WIDE_W'(first_q) + WIDE_W'(count_q) - WIDE_W'(1);
	assign lo        = zone_q ? l_nmin_q : l_dmin_q;
	assign hi        = zone_q ? l_nmax_q : l_dmax_q;
	assign span      = WIDE_W'(hi) - WIDE_W'(lo) + WIDE_W'(1);
	assign need      = CNT_W'(count_q);

	// scan: the read address runs ahead of the evaluated page, which is the read address of the previous cycle
	assign issue_v = rd_p_q <= CNT_W'(hi);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pipe_v_q    <= 1'b0;
			fill_left_q <= '0;
		end else begin
			if (cmd.scan_start) begin
				pipe_v_q <= 1'b0;
			end else if (cmd.scan_step) begin
				pipe_v_q <= issue_v;
			end
			if (cmd.fill_start) begin
				fill_left_q <= cmd.fill_all ? CNT_W'(PAGES) : need;
			end else if (cmd.fill_step) begin
				fill_left_q <= fill_left_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			rd_p_q <= CNT_W'(lo);
			run_q  <= '0;
		end else if (cmd.scan_step) begin
			if (issue_v) begin
				rd_p_q <= rd_p_q + 1'b1;
			end
			eval_p_q <= rd_p_q;
			if (pipe_v_q) begin
				run_q <= rd_data ? '0 : run_q + 1'b1;
			end
			if (sts.scan_found) begin
				start_q <= PG_W'(eval_p_q - run_q);
			end
		end
		if (cmd.fill_start) begin
			fill_ptr_q <= fill_base;
			fill_val_q <= cmd.fill_val;
		end else if (cmd.fill_step) begin
			fill_ptr_q <= fill_ptr_q + 1'b1;
		end
		if (cmd.mul_step) begin
			prod_q <= PROD_W'(start_q) * PROD_W'(PAGE_BYTES);
		end
	end

	always_comb begin
		unique case (cmd.fill_base)
			BASE_ZERO:  fill_base = '0;
			BASE_FIRST: fill_base = PG_W'(first_q);
			BASE_START: fill_base = start_q;
			default:    fill_base = '0;
		endcase
	end

	zbpa_ram #(
		.WIDTH (1),
		.DEPTH (PAGES)
	) u_bitmap (
		.clk   (clk),
		.we    (cmd.fill_step),
		.waddr (fill_ptr_q),
		.wdata (fill_val_q),
		.raddr (rd_p_q[PG_W-1:0]),
		.rdata (rd_data)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.res_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			status_q   <= cmd.res_status;
			addr_out_q <= cmd.res_addr ? ADDR_W'(prod_q) : '0;
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign alloc_address = addr_out_q;

	always_comb begin
		sts.op            = op_q;
		sts.ready         = ready_q;
		sts.div_done      = div_done;
		sts.init_ok       = !init_bad;
		sts.mark_ok       = (WIDE_W'(first_q) >= WIDE_W'(l_dmin_q))
			&& (mark_last <= WIDE_W'(top));
		sts.alloc_reject  = (size_q == '0) || (zone_q && (l_nmin_q == '0));
		sts.alloc_too_big = WIDE_W'(count_q) > span;
		sts.fill_empty    = fill_left_q == '0;
		sts.scan_found    = pipe_v_q && !rd_data
			&& ((CNT_W+1)'(run_q) + (CNT_W+1)'(1) == (CNT_W+1)'(need));
		sts.scan_end      = !issue_v && !pipe_v_q;
		sts.out_free      = !out_valid_q || !out_stall;
	end

endmodule

@@ hdl/zbpa_ctrl.sv @@
// Controller state machine sequencing init, mark and allocate items.
module zbpa_ctrl import zbpa_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  zbpa_sts_t sts,
	output zbpa_cmd_t cmd
);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_DECODE   = 9'b000000010,
		S_DIV_ADDR = 9'b000000100,
		S_DIV_SIZE = 9'b000001000,
		S_CHECK    = 9'b000010000,
		S_SCAN     = 9'b000100000,
		S_MUL      = 9'b001000000,
		S_FILL     = 9'b010000000,
		S_RESP     = 9'b100000000
	} state_t;

	state_t state_q, state_d;
	st_t    res_status_q, res_status_d;
	logic   res_addr_q, res_addr_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			res_status_q <= ST_OK;
			res_addr_q   <= 1'b0;
		end else begin
			state_q      <= state_d;
			res_status_q <= res_status_d;
			res_addr_q   <= res_addr_d;
		end
	end

	always_comb begin
		state_d      = state_q;
		res_status_d = res_status_q;
		res_addr_d   = res_addr_q;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load   = 1'b1;
					res_addr_d = 1'b0;
					state_d    = S_DECODE;
				end
			end
			S_DECODE: begin
				priority if (sts.op == OP_INIT) begin
					state_d = S_CHECK;
				end else if (!sts.ready) begin
					res_status_d = ST_NOT_READY;
					state_d      = S_RESP;
				end else if (sts.op == OP_ALLOC) begin
					cmd.div_start = 1'b1;
					cmd.div_size  = 1'b1;
					state_d       = S_DIV_SIZE;
				end else begin
					cmd.div_start = 1'b1;
					state_d       = S_DIV_ADDR;
				end
			end
			S_DIV_ADDR: begin
				if (sts.div_done) begin
					cmd.save_first = 1'b1;
					cmd.div_start  = 1'b1;
					cmd.div_size   = 1'b1;
					state_d        = S_DIV_SIZE;
				end
			end
			S_DIV_SIZE: begin
				if (sts.div_done) begin
					cmd.save_count = 1'b1;
					state_d        = S_CHECK;
				end
			end
			S_CHECK: begin
				unique case (sts.op)
					OP_INIT: begin
						if (sts.init_ok) begin
							cmd.init_commit = 1'b1;
							cmd.fill_start  = 1'b1;
							cmd.fill_base   = BASE_ZERO;
							cmd.fill_all    = 1'b1;
							cmd.fill_val    = 1'b1;
							res_status_d    = ST_OK;
							state_d         = S_FILL;
						end else begin
							res_status_d = ST_REJECT;
							state_d      = S_RESP;
						end
					end
					OP_FREE, OP_USED: begin
						if (sts.mark_ok) begin
							cmd.fill_start = 1'b1;
							cmd.fill_base  = BASE_FIRST;
							cmd.fill_val   = sts.op == OP_USED;
							res_status_d   = ST_OK;
							state_d        = S_FILL;
						end else begin
							res_status_d = ST_REJECT;
							state_d      = S_RESP;
						end
					end
					OP_ALLOC: begin
						priority if (sts.alloc_reject) begin
							res_status_d = ST_REJECT;
							state_d      = S_RESP;
						end else if (sts.alloc_too_big) begin
							res_status_d = ST_NO_RUN;
							state_d      = S_RESP;
						end else begin
							cmd.scan_start = 1'b1;
							state_d        = S_SCAN;
						end
					end
					default: state_d = S_IDLE;
				endcase
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				priority if (sts.scan_found) begin
					state_d = S_MUL;
				end else if (sts.scan_end) begin
					res_status_d = ST_NO_RUN;
					state_d      = S_RESP;
				end
			end
			S_MUL: begin
				cmd.mul_step   = 1'b1;
				cmd.fill_start = 1'b1;
				cmd.fill_base  = BASE_START;
				cmd.fill_val   = 1'b1;
				res_status_d   = ST_OK;
				res_addr_d     = 1'b1;
				state_d        = S_FILL;
			end
			S_FILL: begin
				if (sts.fill_empty) begin
					state_d = S_RESP;
				end else begin
					cmd.fill_step = 1'b1;
				end
			end
			S_RESP: begin
				if (sts.out_free) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.res_status = res_status_q;
		cmd.res_addr   = res_addr_q;
	end

	assign in_stall = state_q != S_IDLE;

endmodule

@@ hdl/zoned_bitmap_page_allocator.sv @@
// Top level of the zoned bitmap page allocator.
// Usage:
//   Input channel (in_valid/in_stall) carries opcode, byte_address, size_bytes and
//   zone_select; output channel (out_valid/out_stall) returns status and
//   alloc_address, exactly one result per item, in order.
//   Configuration registers are written through cfg_write_en/cfg_index/cfg_data
//   while the block is idle; a successful init copies them into the working bounds.
// Sequencing (one item at a time, one bitmap bit per cycle through a single RAM port):
//   init            the bitmap is swept to all used.
//   mark            two divisions, then the pages marked.
//   allocate        one division, then the pages scanned and the run filled.
//   rejected items  answered after the checks; before init, answered without a division.
//   The worst case is set by the page walk: an allocate that scans and then fills
//   a long run.
// Reset: not initialised, bounds cleared; the bitmap is left as it is, since
//   nothing reads it before a successful init fills it, so no clearing pass runs.
// A stalled result waits in the output register; the next item is taken
//   meanwhile, and its result waits until the register is free.
module zoned_bitmap_page_allocator import zbpa_pkg::*; #(
	parameter int PAGES      = 4096,
	parameter int PAGE_BYTES = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_write_en,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        opcode,
	input  logic [ADDR_W-1:0] byte_address,
	input  logic [SIZE_W-1:0] size_bytes,
	input  logic              zone_select,
	output logic              out_valid,
	input  logic              out_stall,
	output logic [1:0]        status,
	output logic [ADDR_W-1:0] alloc_address
);

	zbpa_cmd_t cmd;
	zbpa_sts_t sts;

	zbpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	zbpa_dp #(
		.PAGES      (PAGES),
		.PAGE_BYTES (PAGE_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write_en  (cfg_write_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.opcode        (opcode),
		.byte_address  (byte_address),
		.size_bytes    (size_bytes),
		.zone_select   (zone_select),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.status        (status),
		.alloc_address (alloc_address),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule
